@@ rtl/pfe_pkg.sv @@
`timescale 1ns / 1ps

package pfe_pkg;

  // Pixel modes as held in the mode register.
  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_GRAY = 2'd1,
    MODE_MONO = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PIXEL_MODE = 2'd0;
  localparam logic [1:0] CFG_ROW_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_FG_COLOR   = 2'd2;
  localparam logic [1:0] CFG_BG_COLOR   = 2'd3;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // A queue entry is either a finished pixel or a one-bit byte to expand.
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_BITS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] data;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

  // Pack 8-bit channels to RGB565.
  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Pack a 24-bit color (red 7:0, green 15:8, blue 23:16) to RGB565.
  function automatic logic [15:0] color_to_565(input logic [23:0] c);
    return pack565(c[7:0], c[15:8], c[23:16]);
  endfunction

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

endpackage

@@ rtl/pfe_front.sv @@
`timescale 1ns / 1ps

module pfe_front import pfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  mode_t       pixel_mode,
  input  logic [23:0] fg_color,
  input  logic [23:0] bg_color,
  input  logic        restart,
  input  logic        q_full,
  output q_port_t     q_push
);

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_blend_r, s1_blend_nxt;
  kind_t       s1_kind_r, s1_kind_nxt;
  logic [15:0] s1_data_r, s1_data_nxt;
  logic [15:0] s1_prod_r [3];
  logic [15:0] prod_nxt [3];
  logic        have_low_r, have_low_nxt;
  logic [7:0]  low_half_r, low_half_nxt;
  logic        accept;
  logic        push;
  logic [7:0]  ratio_inv;

  // The stage holds while its transaction cannot enter the queue.
  assign in_stall = s1_valid_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = s1_valid_r & ~q_full;

  // Blend products per channel: fg * r + bg * (255 - r).
  assign ratio_inv = 8'd255 - in_data_byte;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod_nxt[ch] = 16'(fg_color[8*ch +: 8]) * 16'(in_data_byte)
                   + 16'(bg_color[8*ch +: 8]) * 16'(ratio_inv);
    end
  end

  // Classify the accepted byte by mode and pair raw halves.
  always_comb begin
    s1_valid_nxt = s1_valid_r & ~push;
    s1_blend_nxt = s1_blend_r;
    s1_kind_nxt  = s1_kind_r;
    s1_data_nxt  = s1_data_r;
    have_low_nxt = have_low_r;
    low_half_nxt = low_half_r;
    if (accept) begin
      unique case (pixel_mode)
        MODE_RAW: begin
          if (!have_low_r) begin
            have_low_nxt = 1'b1;
            low_half_nxt = in_data_byte;
          end else begin
            have_low_nxt = 1'b0;
            s1_valid_nxt = 1'b1;
            s1_blend_nxt = 1'b0;
            s1_kind_nxt  = KIND_PIXEL;
            s1_data_nxt  = {in_data_byte, low_half_r};
          end
        end
        MODE_GRAY: begin
          s1_valid_nxt = 1'b1;
          s1_blend_nxt = 1'b1;
          s1_kind_nxt  = KIND_PIXEL;
          s1_data_nxt  = {8'd0, in_data_byte};
        end
        MODE_MONO: begin
          s1_valid_nxt = 1'b1;
          s1_blend_nxt = 1'b0;
          s1_kind_nxt  = KIND_BITS;
          s1_data_nxt  = {8'd0, in_data_byte};
        end
        MODE_NONE: begin
        end
        default: begin
        end
      endcase
    end
    if (restart) begin
      have_low_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      have_low_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      have_low_r <= have_low_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    s1_blend_r <= s1_blend_nxt;
    s1_kind_r  <= s1_kind_nxt;
    s1_data_r  <= s1_data_nxt;
    low_half_r <= low_half_nxt;
    if (accept) begin
      for (int ch = 0; ch < 3; ch++) begin
        s1_prod_r[ch] <= prod_nxt[ch];
      end
    end
  end

  // Finish the blend with the divide by 255 and pack to 565.
  always_comb begin
    q_push.valid      = push;
    q_push.entry.kind = s1_kind_r;
    if (s1_blend_r) begin
      q_push.entry.data = pack565(div255(s1_prod_r[0]), div255(s1_prod_r[1]),
                                  div255(s1_prod_r[2]));
    end else begin
      q_push.entry.data = s1_data_r;
    end
  end

endmodule

@@ rtl/pfe_queue.sv @@
`timescale 1ns / 1ps

module pfe_queue import pfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_port_t q_push,
  output logic    q_full,
  output q_port_t q_head,
  input  logic    pop
);

  q_entry_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign do_push = q_push.valid & ~q_full;
  assign do_pop  = pop & (count_r != '0);

  assign q_head.valid = (count_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

endmodule

@@ rtl/pfe_back.sv @@
`timescale 1ns / 1ps

module pfe_back import pfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_port_t     q_head,
  output logic        pop,
  input  logic [8:0]  width,
  input  logic [23:0] fg_color,
  input  logic [23:0] bg_color,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel,
  output logic        out_end_of_row,
  output logic        out_last
);

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_pixel_r;
  logic        out_eor_r;
  logic        out_last_r;
  logic [8:0]  col_r, col_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic        emit;
  logic [8:0]  col_eff;
  logic [9:0]  col_plus;
  logic        eor;
  logic        last_cur;
  logic [7:0]  bits;
  logic [15:0] pixel_cur;

  // A pixel goes out when the output register is free or being drained.
  assign emit = q_head.valid & (~out_valid_r | ~out_stall);

  // Column position and end of row.
  assign col_eff  = (col_r >= width) ? 9'd0 : col_r;
  assign col_plus = {1'b0, col_eff} + 10'd1;
  assign eor      = (col_plus >= {1'b0, width});
  assign bits     = q_head.entry.data[7:0];

  // Pick the current pixel; a one-bit byte ends at bit 7 or at the row end.
  always_comb begin
    case (q_head.entry.kind)
      KIND_BITS: begin
        pixel_cur = bits[bit_r] ? color_to_565(fg_color) : color_to_565(bg_color);
        last_cur  = (bit_r == 3'd7) | eor;
      end
      default: begin
        pixel_cur = q_head.entry.data;
        last_cur  = 1'b1;
      end
    endcase
  end

  assign pop = emit & last_cur;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    col_nxt       = col_r;
    bit_nxt       = bit_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      col_nxt       = eor ? 9'd0 : col_plus[8:0];
      bit_nxt       = last_cur ? 3'd0 : bit_r + 3'd1;
    end
    if (restart) begin
      col_nxt = 9'd0;
      bit_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      col_r       <= 9'd0;
      bit_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      bit_r       <= bit_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel_r <= pixel_cur;
      out_eor_r   <= eor;
      out_last_r  <= last_cur;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_end_of_row = out_eor_r;
  assign out_last       = out_last_r;

endmodule

@@ rtl/pixel_format_expander_core.sv @@
`timescale 1ns / 1ps
// A byte passes the front stage register and the queue to the output register. Throughput:
// one pixel per cycle while not stalled; raw mode takes two bytes per pixel, grayscale one,
// and one-bit mode one byte per up to eight pixels, set by the single pixel port of the back.
// Reset (synchronous, rst_n low) restores the register defaults, clears the row
// position and any held raw half, and empties the queue and the output register.

module pixel_format_expander_core import pfe_pkg::*; #(
  parameter int MAX_WIDTH = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel,
  output logic        out_end_of_row,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam logic [8:0] MaxWidth9 = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);

  mode_t       mode_r;
  logic [8:0]  row_width_r;
  logic [23:0] fg_color_r;
  logic [23:0] bg_color_r;
  logic        restart;
  logic [8:0]  width;
  logic        q_full;
  q_port_t     q_push;
  q_port_t     q_head;
  logic        pop;

  // A write to the mode or the width starts a new row.
  assign restart = cfg_we & ((cfg_index == CFG_PIXEL_MODE) | (cfg_index == CFG_ROW_WIDTH));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RAW;
      row_width_r <= 9'd1;
      fg_color_r  <= 24'hFFFFFF;
      bg_color_r  <= 24'h000000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_MODE: mode_r      <= mode_t'(cfg_wdata[1:0]);
        CFG_ROW_WIDTH:  row_width_r <= cfg_wdata[8:0];
        CFG_FG_COLOR:   fg_color_r  <= cfg_wdata;
        CFG_BG_COLOR:   bg_color_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Width in force: zero counts as one, and the width saturates at the maximum.
  always_comb begin
    if (row_width_r == 9'd0) begin
      width = 9'd1;
    end else if (row_width_r > MaxWidth9) begin
      width = MaxWidth9;
    end else begin
      width = row_width_r;
    end
  end

  pfe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .pixel_mode   (mode_r),
    .fg_color     (fg_color_r),
    .bg_color     (bg_color_r),
    .restart      (restart),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  pfe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .pop    (pop)
  );

  pfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .pop            (pop),
    .width          (width),
    .fg_color       (fg_color_r),
    .bg_color       (bg_color_r),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel      (out_pixel),
    .out_end_of_row (out_end_of_row),
    .out_last       (out_last)
  );

endmodule

@@ bench/pixel_stream_checker.sv @@
`timescale 1ns / 1ps

module pixel_stream_checker import pfe_pkg::*; #(
  parameter int MAX_WIDTH = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_pixel,
  input  logic        out_end_of_row,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          pixels_outstanding = 0,
  output int          mismatch_count = 0
);

  typedef struct packed {
    logic [15:0] pixel;
    logic        end_of_row;
    logic        last;
  } pixel_exp_t;

  pixel_exp_t expected_pixels[$];

  // Shadow copy of the configuration registers.
  mode_t       mode = MODE_RAW;
  logic [8:0]  row_width = 9'd1;
  logic [23:0] fg_color = 24'hFFFFFF;
  logic [23:0] bg_color = 24'h000000;

  // Shadow copy of the row position and the held raw byte.
  int          column = 0;
  logic [7:0]  low_half = 8'h00;
  logic        have_low_half = 1'b0;
  int          errs = 0;

  function automatic logic [15:0] color565(input logic [23:0] c);
    return {c[7:3], c[15:10], c[23:19]};
  endfunction

  // Per-channel mix of foreground and background, weighted by the byte.
  function automatic logic [15:0] blend565(input logic [23:0] fg, input logic [23:0] bg,
                                           input logic [7:0] ratio);
    int a;
    int b;
    int r;
    int mix;
    logic [7:0] ch [3];
    r = ratio;
    for (int i = 0; i < 3; i++) begin
      a = fg[8*i +: 8];
      b = bg[8*i +: 8];
      mix = (a * r + b * (255 - r)) / 255;
      ch[i] = mix[7:0];
    end
    return {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
  endfunction

  // Queue one pixel at the current column and move along the row.
  task automatic emit_pixel(input logic [15:0] px, input int w, input logic is_last);
    pixel_exp_t e;
    e.pixel = px;
    e.end_of_row = (column + 1 >= w);
    e.last = is_last;
    column = e.end_of_row ? 0 : column + 1;
    expected_pixels.push_back(e);
  endtask

  // Work out the pixels that one accepted byte produces.
  task automatic predict_pixels(input logic [7:0] b);
    int w;
    int n;
    if (mode == MODE_NONE) return;
    if (row_width == 9'd0) w = 1;
    else if (row_width > MAX_WIDTH) w = MAX_WIDTH;
    else w = row_width;
    if (column >= w) column = 0;
    case (mode)
      MODE_RAW: begin
        if (!have_low_half) begin
          low_half = b;
          have_low_half = 1'b1;
        end else begin
          have_low_half = 1'b0;
          emit_pixel({b, low_half}, w, 1'b1);
        end
      end
      MODE_GRAY: begin
        emit_pixel(blend565(fg_color, bg_color, b), w, 1'b1);
      end
      default: begin
        n = (w - column > 8) ? 8 : w - column;
        for (int k = 0; k < n; k++) begin
          emit_pixel(b[k] ? color565(fg_color) : color565(bg_color), w, k == n - 1);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    pixel_exp_t want;
    if (!rst_n) begin
      mode = MODE_RAW;
      row_width = 9'd1;
      fg_color = 24'hFFFFFF;
      bg_color = 24'h000000;
      column = 0;
      low_half = 8'h00;
      have_low_half = 1'b0;
      expected_pixels.delete();
    end else begin
      // Compare each pixel transaction against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel %h (end_of_row %b, last %b)",
                 out_pixel, out_end_of_row, out_last);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel !== want.pixel) begin
            $error("pixel: expected %h, got %h", want.pixel, out_pixel);
            errs++;
          end
          if (out_end_of_row !== want.end_of_row) begin
            $error("end_of_row: expected %b, got %b", want.end_of_row, out_end_of_row);
            errs++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            errs++;
          end
        end
      end

      // Register writes; a mode or width write restarts the row.
      if (cfg_we) begin
        case (cfg_index)
          CFG_PIXEL_MODE: begin
            mode = mode_t'(cfg_wdata[1:0]);
            column = 0;
            have_low_half = 1'b0;
          end
          CFG_ROW_WIDTH: begin
            row_width = cfg_wdata[8:0];
            column = 0;
            have_low_half = 1'b0;
          end
          CFG_FG_COLOR: fg_color = cfg_wdata;
          CFG_BG_COLOR: bg_color = cfg_wdata;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) predict_pixels(in_data_byte);
    end
    pixels_outstanding <= expected_pixels.size();
    mismatch_count <= errs;
  end

endmodule

@@ bench/pixel_format_expander_core_tb.sv @@
`timescale 1ns / 1ps

module pixel_format_expander_core_tb import pfe_pkg::*;;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int BYTES_PER_PHASE = 20;

  typedef enum {RX_READY, RX_RANDOM, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_pixel;
  logic        out_end_of_row;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_PIXEL_MODE;
  logic [23:0] cfg_wdata = 24'h000000;

  int          pixels_outstanding;
  int          mismatch_count;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  rx_pattern_t rx_pattern = RX_READY;

  pixel_format_expander_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel      (out_pixel),
    .out_end_of_row (out_end_of_row),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  pixel_stream_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel          (out_pixel),
    .out_end_of_row     (out_end_of_row),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .pixels_outstanding (pixels_outstanding),
    .mismatch_count     (mismatch_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The pixel receiver stalls on a pattern that is redrawn at random intervals.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (rx_pattern)
      RX_READY:  out_stall <= 1'b0;
      RX_RANDOM: out_stall <= $urandom_range(0, 1);
      RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      default:   out_stall <= (stall_left % 3 == 0);
    endcase
  end

  // Offer one byte in bursts with random gaps, and return once it is taken.
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  // Hold off the sender until every predicted pixel has come out.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(negedge clk); while (pixels_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input mode_t m, input logic [8:0] w, input logic [23:0] fg,
                           input logic [23:0] bg);
    write_reg(CFG_PIXEL_MODE, 24'(m));
    write_reg(CFG_ROW_WIDTH, 24'(w));
    write_reg(CFG_FG_COLOR, fg);
    write_reg(CFG_BG_COLOR, bg);
  endtask

  function automatic logic [23:0] random_color();
    case ($urandom_range(0, 5))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [8:0] random_width();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd480;
      2:       return 9'd511;
      3:       return 9'($urandom_range(8, 511));
      default: return 9'($urandom_range(1, 20));
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Raw pixels with the reset configuration: low byte first, one pixel per row.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hAA);
    drain_pixels();

    // A held low byte is dropped when the row width is rewritten.
    send_byte(8'h3C);
    drain_pixels();
    write_reg(CFG_ROW_WIDTH, 24'd4);
    send_byte(8'h81);
    send_byte(8'h7E);
    drain_pixels();

    // Grayscale blend at both ratio extremes and the middle, then colors swapped.
    configure(MODE_GRAY, 9'd3, 24'hFFFFFF, 24'h000000);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    drain_pixels();
    write_reg(CFG_FG_COLOR, 24'h000000);
    write_reg(CFG_BG_COLOR, 24'hFFFFFF);
    send_byte(8'h01);
    send_byte(8'hFE);
    drain_pixels();

    // One-bit mode: the second byte of a ten-pixel row keeps only two bits.
    configure(MODE_MONO, 9'd10, 24'h12F4A8, 24'h8B0C57);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    drain_pixels();

    // Zero width acts as one pixel; an oversized width saturates.
    write_reg(CFG_ROW_WIDTH, 24'd0);
    send_byte(8'hA5);
    drain_pixels();
    write_reg(CFG_ROW_WIDTH, 24'd511);
    send_byte(8'h5A);
    drain_pixels();

    // The unused mode swallows bytes without output.
    write_reg(CFG_PIXEL_MODE, 24'(MODE_NONE));
    send_byte(8'h33);
    send_byte(8'hCC);
    drain_pixels();

    // Random phases, each under a fresh configuration.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(mode_t'($urandom_range(0, 2)), random_width(), random_color(), random_color());
      for (int i = 0; i < BYTES_PER_PHASE; i++) begin
        send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 15) == 0) drain_pixels();
      end
      drain_pixels();
    end

    drain_pixels();
    if (mismatch_count == 0 && pixels_outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
